[sv/kmpp_pkg.sv]
// shared types and constants for the keyboard and mouse packet parser
package kmpp_pkg;

    typedef enum logic [1:0] {
        PH_KEYBOARD = 2'd0,
        PH_HEADER   = 2'd1,
        PH_X        = 2'd2,
        PH_Y        = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_PUSH = 3'd1,
        OP_POP  = 3'd2,
        OP_HDR  = 3'd3,
        OP_X    = 3'd4,
        OP_Y    = 3'd5
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        t_phase     phase;
    } t_op;

    localparam logic [1:0] CFG_ESCAPE  = 2'd0;
    localparam logic [1:0] CFG_X_LIMIT = 2'd1;
    localparam logic [1:0] CFG_Y_LIMIT = 2'd2;

    localparam logic [7:0] ESCAPE_RESET  = 8'd129;
    localparam logic [9:0] X_LIMIT_RESET = 10'd639;
    localparam logic [9:0] Y_LIMIT_RESET = 10'd399;

    localparam logic [7:0] MOUSE_START = 8'hF8;
    localparam logic [7:0] MAG_MASK    = 8'h7F;
    localparam logic [7:0] HDR_LEFT    = 8'h02;
    localparam logic [7:0] HDR_RIGHT   = 8'h01;

endpackage

[sv/keyboard_mouse_packet_parser.sv]
// top level of the keyboard and mouse packet parser
//
// input channel: i_in_valid / o_in_stall carry one word, either a received
// controller byte (i_kind = 0, i_rx_byte) or a pop request (i_kind = 1).
// output channel: o_out_valid / i_out_stall carry one result word for every
// input word: popped code, queue level, drop flag, pointer, buttons, phase.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 escape break code, 1 x limit, 2 y limit; o_cfg_ready is always high.
// a word is first classified into the two-entry queue; the back end then
// registers its result together with the key memory read.
// throughput: one word per cycle while the receiver does not stall.
// when the receiver stalls, the result holds, the back end stops and the
// queue fills; o_in_stall rises only once both queue entries are taken.
// reset (synchronous, active low) empties the key queue, returns to keyboard
// mode, zeroes pointer and buttons and loads the config reset values.
module keyboard_mouse_packet_parser #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_popped_code,
    output logic        o_pop_valid,
    output logic [8:0]  o_queue_level,
    output logic        o_dropped,
    output logic [9:0]  o_pointer_x,
    output logic [9:0]  o_pointer_y,
    output logic        o_left_pressed,
    output logic        o_right_pressed,
    output logic [1:0]  o_parse_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic [7:0]    r_escape;
    logic [9:0]    r_x_limit;
    logic [9:0]    r_y_limit;

    logic          link_full;
    logic          link_valid;
    logic          accept;
    logic          take;
    kmpp_pkg::t_op front_op;
    kmpp_pkg::t_op back_op;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = link_full;
    assign accept      = i_in_valid && !link_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape  <= kmpp_pkg::ESCAPE_RESET;
            r_x_limit <= kmpp_pkg::X_LIMIT_RESET;
            r_y_limit <= kmpp_pkg::Y_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kmpp_pkg::CFG_ESCAPE:  r_escape  <= i_cfg_data[7:0];
                kmpp_pkg::CFG_X_LIMIT: r_x_limit <= i_cfg_data;
                kmpp_pkg::CFG_Y_LIMIT: r_y_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    kmpp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_kind    (i_kind),
        .i_rx_byte (i_rx_byte),
        .i_escape  (r_escape),
        .o_op      (front_op)
    );

    kmpp_link u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_op    (front_op),
        .o_full  (link_full),
        .i_pop   (take),
        .o_valid (link_valid),
        .o_op    (back_op)
    );

    kmpp_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (link_valid),
        .i_op            (back_op),
        .o_take          (take),
        .i_x_limit       (r_x_limit),
        .i_y_limit       (r_y_limit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_popped_code   (o_popped_code),
        .o_pop_valid     (o_pop_valid),
        .o_queue_level   (o_queue_level),
        .o_dropped       (o_dropped),
        .o_pointer_x     (o_pointer_x),
        .o_pointer_y     (o_pointer_y),
        .o_left_pressed  (o_left_pressed),
        .o_right_pressed (o_right_pressed),
        .o_parse_phase   (o_parse_phase)
    );

endmodule

[sv/kmpp_front.sv]
// front end: tracks the packet phase and classifies each incoming word
module kmpp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_kind,
    input  logic [7:0]      i_rx_byte,
    input  logic [7:0]      i_escape,
    output kmpp_pkg::t_op   o_op
);

    kmpp_pkg::t_phase r_phase;
    kmpp_pkg::t_phase n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kmpp_pkg::PH_KEYBOARD;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (!i_kind) begin
            case (r_phase)
                kmpp_pkg::PH_KEYBOARD: begin
                    if (i_rx_byte[7] && i_rx_byte != i_escape
                        && i_rx_byte >= kmpp_pkg::MOUSE_START) begin
                        n_phase = kmpp_pkg::PH_HEADER;
                    end
                end
                kmpp_pkg::PH_HEADER: n_phase = kmpp_pkg::PH_X;
                kmpp_pkg::PH_X:      n_phase = kmpp_pkg::PH_Y;
                kmpp_pkg::PH_Y:      n_phase = kmpp_pkg::PH_KEYBOARD;
                default:             n_phase = kmpp_pkg::PH_KEYBOARD;
            endcase
        end
    end

    // classified operation
    always_comb begin
        o_op.kind  = kmpp_pkg::OP_NONE;
        o_op.data  = i_rx_byte;
        o_op.phase = n_phase;
        if (i_kind) begin
            o_op.kind = kmpp_pkg::OP_POP;
        end else begin
            case (r_phase)
                kmpp_pkg::PH_KEYBOARD: begin
                    if (!i_rx_byte[7] || i_rx_byte == i_escape) begin
                        o_op.kind = kmpp_pkg::OP_PUSH;
                    end
                end
                kmpp_pkg::PH_HEADER: o_op.kind = kmpp_pkg::OP_HDR;
                kmpp_pkg::PH_X:      o_op.kind = kmpp_pkg::OP_X;
                kmpp_pkg::PH_Y:      o_op.kind = kmpp_pkg::OP_Y;
                default:             o_op.kind = kmpp_pkg::OP_NONE;
            endcase
        end
    end

endmodule

[sv/kmpp_link.sv]
// two-entry queue between the front end and the back end
module kmpp_link (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kmpp_pkg::t_op   i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output kmpp_pkg::t_op   o_op
);

    kmpp_pkg::t_op r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_slot[r_rd];

endmodule

[sv/kmpp_back.sv]
// back end: key queue, pointer and button state, result register
module kmpp_back #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  kmpp_pkg::t_op   i_op,
    output logic            o_take,
    input  logic [9:0]      i_x_limit,
    input  logic [9:0]      i_y_limit,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_popped_code,
    output logic            o_pop_valid,
    output logic [8:0]      o_queue_level,
    output logic            o_dropped,
    output logic [9:0]      o_pointer_x,
    output logic [9:0]      o_pointer_y,
    output logic            o_left_pressed,
    output logic            o_right_pressed,
    output logic [1:0]      o_parse_phase
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [7:0]    r_mem_q;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [9:0]    r_cx;
    logic [9:0]    r_cy;
    logic          r_left;
    logic          r_right;
    logic          r_out_valid;
    logic          r_pop_valid;
    logic          r_dropped;
    logic [1:0]    r_phase;

    logic          exec;
    logic          do_push;
    logic          do_pop;
    logic          is_full;
    logic [9:0]    delta_pos;
    logic [9:0]    delta_lim;
    logic [9:0]    delta_res;
    logic [11:0]   delta_sum;
    logic [11:0]   delta_mag;

    assign exec    = i_valid && (!r_out_valid || !i_out_stall);
    assign o_take  = exec;
    assign is_full = (r_count == FULL);
    assign do_push = exec && (i_op.kind == kmpp_pkg::OP_PUSH) && !is_full;
    assign do_pop  = exec && (i_op.kind == kmpp_pkg::OP_POP) && (r_count != '0);

    // sign-magnitude delta with clamp to [0, limit]
    always_comb begin
        delta_pos = (i_op.kind == kmpp_pkg::OP_X) ? r_cx : r_cy;
        delta_lim = (i_op.kind == kmpp_pkg::OP_X) ? i_x_limit : i_y_limit;
        delta_mag = {4'd0, i_op.data & kmpp_pkg::MAG_MASK};
        if (i_op.data[7]) begin
            delta_sum = {2'd0, delta_pos} - delta_mag;
        end else begin
            delta_sum = {2'd0, delta_pos} + delta_mag;
        end
        if (delta_sum[11]) begin
            delta_res = 10'd0;
        end else if (delta_sum > {2'd0, delta_lim}) begin
            delta_res = delta_lim;
        end else begin
            delta_res = delta_sum[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op.data;
        end
        if (do_pop) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_cx        <= 10'd0;
            r_cy        <= 10'd0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
                r_count  <= r_count + CW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
                r_count  <= r_count - CW'(1);
            end
            if (exec) begin
                case (i_op.kind)
                    kmpp_pkg::OP_HDR: begin
                        r_left  <= |(i_op.data & kmpp_pkg::HDR_LEFT);
                        r_right <= !(|(i_op.data & kmpp_pkg::HDR_LEFT))
                                   && |(i_op.data & kmpp_pkg::HDR_RIGHT);
                    end
                    kmpp_pkg::OP_X: begin
                        r_cx <= delta_res;
                    end
                    kmpp_pkg::OP_Y: begin
                        r_cy    <= delta_res;
                        r_left  <= 1'b0;
                        r_right <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_pop_valid <= do_pop;
            r_dropped   <= (i_op.kind == kmpp_pkg::OP_PUSH) && is_full;
            r_phase     <= i_op.phase;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_popped_code   = r_pop_valid ? r_mem_q : 8'd0;
    assign o_pop_valid     = r_pop_valid;
    assign o_queue_level   = 9'(r_count);
    assign o_dropped       = r_dropped;
    assign o_pointer_x     = r_cx;
    assign o_pointer_y     = r_cy;
    assign o_left_pressed  = r_left;
    assign o_right_pressed = r_right;
    assign o_parse_phase   = r_phase;

endmodule

[tb/sv/kmpp_checker.sv]
// scoreboard for the keyboard and mouse packet parser: predicts each result word and compares
`timescale 1ns / 100ps
module kmpp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_popped_code,
    input  logic       i_pop_valid,
    input  logic [8:0] i_queue_level,
    input  logic       i_dropped,
    input  logic [9:0] i_pointer_x,
    input  logic [9:0] i_pointer_y,
    input  logic       i_left_pressed,
    input  logic       i_right_pressed,
    input  logic [1:0] i_parse_phase,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    import kmpp_pkg::*;

    localparam int KEY_DEPTH = 256;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] popped_code;
        logic       pop_valid;
        logic [8:0] queue_level;
        logic       dropped;
        logic [9:0] pointer_x;
        logic [9:0] pointer_y;
        logic       left_pressed;
        logic       right_pressed;
        t_phase     parse_phase;
    } t_status;

    logic [7:0] escape_code;
    logic [9:0] x_lim;
    logic [9:0] y_lim;
    logic [7:0] key_fifo [KEY_DEPTH];
    logic [7:0] rd_ptr;
    logic [7:0] wr_ptr;
    logic [8:0] key_count;
    logic [9:0] cur_x;
    logic [9:0] cur_y;
    logic       left_btn;
    logic       right_btn;
    t_phase     parse_st;
    t_status    status_q[$];
    int         fails = 0;

    function automatic logic [9:0] move_axis(logic [9:0] pos, logic [7:0] delta,
                                             logic [9:0] lim);
        int mag;
        int v;
        mag = int'(delta & MAG_MASK);
        v = delta[7] ? int'(pos) - mag : int'(pos) + mag;
        if (v < 0) begin
            v = 0;
        end else if (v > int'(lim)) begin
            v = int'(lim);
        end
        return v[9:0];
    endfunction

    function automatic t_status next_status(logic pop_req, logic [7:0] b);
        t_status s;
        s = '0;
        if (pop_req) begin
            if (key_count != 0) begin
                s.popped_code = key_fifo[rd_ptr];
                s.pop_valid = 1'b1;
                rd_ptr = rd_ptr + 1'b1;
                key_count = key_count - 1'b1;
            end
        end else begin
            case (parse_st)
                PH_KEYBOARD: begin
                    if (!b[7] || b == escape_code) begin
                        if (key_count >= KEY_DEPTH) begin
                            s.dropped = 1'b1;
                        end else begin
                            key_fifo[wr_ptr] = b;
                            wr_ptr = wr_ptr + 1'b1;
                            key_count = key_count + 1'b1;
                        end
                    end else if (b >= MOUSE_START) begin
                        parse_st = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    left_btn = (b & HDR_LEFT) != 0;
                    right_btn = !left_btn && ((b & HDR_RIGHT) != 0);
                    parse_st = PH_X;
                end
                PH_X: begin
                    cur_x = move_axis(cur_x, b, x_lim);
                    parse_st = PH_Y;
                end
                default: begin
                    cur_y = move_axis(cur_y, b, y_lim);
                    left_btn = 1'b0;
                    right_btn = 1'b0;
                    parse_st = PH_KEYBOARD;
                end
            endcase
        end
        s.queue_level = key_count;
        s.pointer_x = cur_x;
        s.pointer_y = cur_y;
        s.left_pressed = left_btn;
        s.right_pressed = right_btn;
        s.parse_phase = parse_st;
        return s;
    endfunction

    function automatic string show(t_status s);
        return $sformatf({"code %02h valid %0d level %0d drop %0d x %0d y %0d",
                          " left %0d right %0d phase %0d"},
                         s.popped_code, s.pop_valid, s.queue_level, s.dropped, s.pointer_x,
                         s.pointer_y, s.left_pressed, s.right_pressed, s.parse_phase);
    endfunction

    task automatic note_fail(input string msg);
        if (fails < REPORT_MAX) begin
            $display("%s", msg);
        end
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            escape_code = ESCAPE_RESET;
            x_lim = X_LIMIT_RESET;
            y_lim = Y_LIMIT_RESET;
            rd_ptr = '0;
            wr_ptr = '0;
            key_count = '0;
            cur_x = '0;
            cur_y = '0;
            left_btn = 1'b0;
            right_btn = 1'b0;
            parse_st = PH_KEYBOARD;
            status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.popped_code = i_popped_code;
                got.pop_valid = i_pop_valid;
                got.queue_level = i_queue_level;
                got.dropped = i_dropped;
                got.pointer_x = i_pointer_x;
                got.pointer_y = i_pointer_y;
                got.left_pressed = i_left_pressed;
                got.right_pressed = i_right_pressed;
                got.parse_phase = t_phase'(i_parse_phase);
                if (status_q.size() == 0) begin
                    note_fail($sformatf("%0t: unexpected word: %s", $realtime, show(got)));
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        note_fail($sformatf("%0t: mismatch\n  expected %s\n  actual   %s",
                                            $realtime, show(want), show(got)));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ESCAPE:  escape_code = i_cfg_data[7:0];
                    CFG_X_LIMIT: x_lim = i_cfg_data;
                    CFG_Y_LIMIT: y_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(next_status(i_kind, i_rx_byte));
            end
        end
        o_pending <= status_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/keyboard_mouse_packet_parser_tb.sv]
// testbench top for the keyboard and mouse packet parser: stimulus, idling phases and verdict
`timescale 1ns / 100ps
module keyboard_mouse_packet_parser_tb;
    import kmpp_pkg::*;

    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_POP = 1'b1;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_kind = 1'b0;
    logic [7:0] i_rx_byte = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [9:0] i_cfg_data = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_popped_code;
    logic       o_pop_valid;
    logic [8:0] o_queue_level;
    logic       o_dropped;
    logic [9:0] o_pointer_x;
    logic [9:0] o_pointer_y;
    logic       o_left_pressed;
    logic       o_right_pressed;
    logic [1:0] o_parse_phase;
    logic       o_cfg_ready;

    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    int         quiet_cycles = 0;
    int         fail_count;
    int         pending;
    logic [7:0] cur_escape = ESCAPE_RESET;

    always #5 i_clk = ~i_clk;

    keyboard_mouse_packet_parser dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_popped_code(o_popped_code),
        .o_pop_valid(o_pop_valid),
        .o_queue_level(o_queue_level),
        .o_dropped(o_dropped),
        .o_pointer_x(o_pointer_x),
        .o_pointer_y(o_pointer_y),
        .o_left_pressed(o_left_pressed),
        .o_right_pressed(o_right_pressed),
        .o_parse_phase(o_parse_phase),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    kmpp_checker scoreboard (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_rx_byte(i_rx_byte),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_popped_code(o_popped_code),
        .i_pop_valid(o_pop_valid),
        .i_queue_level(o_queue_level),
        .i_dropped(o_dropped),
        .i_pointer_x(o_pointer_x),
        .i_pointer_y(o_pointer_y),
        .i_left_pressed(o_left_pressed),
        .i_right_pressed(o_right_pressed),
        .i_parse_phase(o_parse_phase),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[keyboard_mouse_packet_parser] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] esc, input logic [9:0] xl, input logic [9:0] yl);
        write_reg(CFG_ESCAPE, {2'($urandom), esc});
        write_reg(CFG_X_LIMIT, xl);
        write_reg(CFG_Y_LIMIT, yl);
        i_cfg_valid <= 1'b0;
        cur_escape = esc;
    endtask

    // wait until every expected word is back, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] key_byte();
        if ($urandom_range(0, 7) == 0) begin
            return cur_escape;
        end else if ($urandom_range(0, 3) != 0) begin
            return 8'($urandom_range(0, 127));
        end
        return 8'($urandom);
    endfunction

    // mouse packet with random content, pops mixed in, sometimes cut short
    task automatic send_packet(input bit broken, output int n_sent);
        int len;
        len = broken ? $urandom_range(1, 3) : 4;
        n_sent = len;
        send_word(KIND_RX, 8'($urandom_range(MOUSE_START, 255)));
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(KIND_POP, 8'($urandom));
                n_sent++;
            end
            send_word(KIND_RX, 8'($urandom));
        end
    endtask

    task automatic run_random(input int n_words, input int push_w, input int pop_w);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < push_w) begin
                send_word(KIND_RX, key_byte());
                sent++;
            end else if (pick < push_w + pop_w) begin
                send_word(KIND_POP, 8'($urandom));
                sent++;
            end else begin
                send_packet($urandom_range(0, 9) == 0, n);
                sent += n;
            end
        end
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct <= snk_pct;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keyboard codes, escape break, dropped breaks, pops down to empty
        send_word(KIND_RX, 8'h00);
        send_word(KIND_RX, 8'h7F);
        send_word(KIND_RX, 8'h80);
        send_word(KIND_RX, ESCAPE_RESET);
        send_word(KIND_RX, 8'hF7);
        send_word(KIND_POP, 8'hFF);
        send_word(KIND_POP, 8'h00);
        send_word(KIND_POP, 8'hA5);
        send_word(KIND_POP, 8'h5A);
        // packets: both buttons, right only, largest deltas, minus zero
        send_word(KIND_RX, MOUSE_START);
        send_word(KIND_RX, 8'h03);
        send_word(KIND_RX, 8'h7F);
        send_word(KIND_RX, 8'h7F);
        send_word(KIND_RX, 8'hFF);
        send_word(KIND_RX, HDR_RIGHT);
        send_word(KIND_RX, 8'hFF);
        send_word(KIND_RX, 8'h80);
        // pops inside a packet
        send_word(KIND_RX, MOUSE_START);
        send_word(KIND_POP, 8'h00);
        send_word(KIND_RX, 8'h00);
        send_word(KIND_POP, 8'h00);
        send_word(KIND_RX, 8'h05);
        send_word(KIND_RX, 8'h85);
        send_word(KIND_RX, 8'h55);
        send_word(KIND_POP, 8'h00);

        run_random(250, 40, 25);

        settle();
        configure(8'hFF, 10'd0, 10'd1023);
        set_idling(76, 0);
        run_random(450, 85, 5);

        settle();
        configure(8'h00, 10'd1023, 10'd0);
        set_idling(0, 76);
        run_random(250, 25, 50);

        settle();
        configure(8'($urandom), 10'($urandom), 10'($urandom));
        set_idling(8, 8);
        run_random(250, 40, 25);

        settle();
        configure(MOUSE_START, 10'd5, 10'd7);
        set_idling(0, 0);
        run_random(250, 85, 5);

        settle();
        configure(8'($urandom_range(128, 255)), 10'($urandom), 10'($urandom));
        set_idling(76, 0);
        run_random(200, 25, 50);

        settle();
        configure(8'($urandom), 10'($urandom), 10'($urandom));
        set_idling(0, 76);
        run_random(200, 40, 25);

        set_idling(8, 8);
        run_random(200, 40, 25);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("[keyboard_mouse_packet_parser] OK");
        end else begin
            $display("[keyboard_mouse_packet_parser] ERROR");
        end
        $finish;
    end

endmodule
